[rtl/pngunf_pkg.sv]
`default_nettype none

package pngunf_pkg;

    localparam int MAX_ROW_BYTES   = 4096;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int BYTE_W = 8;
    localparam int BPP_W  = 4;
    localparam int LEN_W  = 13;
    localparam int CFG_W  = 13;
    localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int ROW_AW = $clog2(MAX_ROW_BYTES);
    localparam int PIX_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    typedef logic [BYTE_W-1:0] byte_t;

    localparam byte_t FILT_NONE  = 8'd0;
    localparam byte_t FILT_SUB   = 8'd1;
    localparam byte_t FILT_UP    = 8'd2;
    localparam byte_t FILT_AVG   = 8'd3;
    localparam byte_t FILT_PAETH = 8'd4;

    typedef enum logic {
        REG_BPP = 1'b0,
        REG_LEN = 1'b1
    } cfg_reg_t;

    // ties resolve to left, then above, then upper-left
    function automatic byte_t paeth(input byte_t a, input byte_t b, input byte_t c);
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        byte_t              res;
        sa = signed'({3'b000, a});
        sb = signed'({3'b000, b});
        sc = signed'({3'b000, c});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) begin
            res = a;
        end else if (db <= dc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/png_scanline_unfilter.sv]
`default_nettype none

// Channel   Dir  Transfer on          tdata        tuser        tlast
// s_        in   s_tvalid & s_tready  raw_byte     first_row    -
// m_        out  m_tvalid & m_tready  pixel_byte   bad_filter   row_end
// cfg_      in   cfg_we               reg data     -            -
//
// One byte per clock sustained while the output is not stalled; filter type bytes give no result.
// Row store read (registered) in stage 1, then reconstruction into the
// output register.
// Row store needs no clearing pass: a fill mark makes unwritten entries read zero.
// aresetn is synchronous, active low; a stalled output holds stage 1 and input.
module png_scanline_unfilter (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [7:0]                         s_tdata,   // [7:0] raw_byte
    input  wire                                s_tuser,   // [0] first_row
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] pixel_byte
    output logic                               m_tuser,   // [0] bad_filter
    output logic                               m_tlast,
    input  wire                                cfg_we,
    input  wire  pngunf_pkg::cfg_reg_t         cfg_index,
    input  wire  [pngunf_pkg::CFG_W-1:0]       cfg_data
);

    logic [pngunf_pkg::BPP_W-1:0]  bpp_reg;
    logic [pngunf_pkg::LEN_W-1:0]  len_reg;
    logic [pngunf_pkg::POS_W-1:0]  pos_reg;
    pngunf_pkg::byte_t             filter_reg;
    logic [pngunf_pkg::POS_W-1:0]  fill_reg;

    logic                          s1_valid_reg;
    pngunf_pkg::byte_t             s1_raw_reg;
    pngunf_pkg::byte_t             s1_filter_reg;
    logic [pngunf_pkg::ROW_AW-1:0] s1_j_reg;
    logic                          s1_fr_reg;
    logic                          s1_last_reg;
    logic                          s1_hit_reg;
    pngunf_pkg::byte_t             rd_data_reg;

    pngunf_pkg::byte_t             left_hist_reg [pngunf_pkg::MAX_PIXEL_BYTES];
    pngunf_pkg::byte_t             ul_hist_reg   [pngunf_pkg::MAX_PIXEL_BYTES];
    pngunf_pkg::byte_t             row_mem       [pngunf_pkg::MAX_ROW_BYTES];

    logic                          m_valid_reg;
    pngunf_pkg::byte_t             m_data_reg;
    logic                          m_bad_reg;
    logic                          m_last_reg;

    logic                          s_accept;
    logic                          data_accept;
    logic                          s1_adv;
    logic [pngunf_pkg::BPP_W-1:0]  bpp_eff;
    logic [pngunf_pkg::LEN_W-1:0]  len_eff;
    logic [pngunf_pkg::POS_W-1:0]  pos_dec;
    logic [pngunf_pkg::ROW_AW-1:0] rd_j;
    logic                          rd_last;
    logic [pngunf_pkg::PIX_IW-1:0] bpp_idx;
    logic                          s1_start;
    pngunf_pkg::byte_t             stored;
    pngunf_pkg::byte_t             left_b;
    pngunf_pkg::byte_t             above_b;
    pngunf_pkg::byte_t             upleft_b;
    logic [8:0]                    avg_sum;
    pngunf_pkg::byte_t             recon;
    logic [pngunf_pkg::POS_W-1:0]  s1_j_inc;

    always_comb begin
        if (bpp_reg == '0) begin
            bpp_eff = pngunf_pkg::BPP_W'(1);
        end else if (bpp_reg > pngunf_pkg::BPP_W'(pngunf_pkg::MAX_PIXEL_BYTES)) begin
            bpp_eff = pngunf_pkg::BPP_W'(pngunf_pkg::MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = bpp_reg;
        end
        if (len_reg == '0) begin
            len_eff = pngunf_pkg::LEN_W'(1);
        end else if (len_reg > pngunf_pkg::LEN_W'(pngunf_pkg::MAX_ROW_BYTES)) begin
            len_eff = pngunf_pkg::LEN_W'(pngunf_pkg::MAX_ROW_BYTES);
        end else begin
            len_eff = len_reg;
        end
    end

    assign s1_adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready    = !s1_valid_reg || s1_adv;
    assign s_accept    = s_tvalid && s_tready;
    assign data_accept = s_accept && (pos_reg != '0);

    assign pos_dec = pos_reg - pngunf_pkg::POS_W'(1);
    assign rd_j    = pos_dec[pngunf_pkg::ROW_AW-1:0];
    assign rd_last = pngunf_pkg::LEN_W'(pos_reg) >= len_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= pngunf_pkg::BPP_W'(1);
            len_reg <= pngunf_pkg::LEN_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                pngunf_pkg::REG_BPP: bpp_reg <= cfg_data[pngunf_pkg::BPP_W-1:0];
                pngunf_pkg::REG_LEN: len_reg <= cfg_data[pngunf_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            filter_reg <= pngunf_pkg::FILT_NONE;
        end else if (s_accept) begin
            if (pos_reg == '0) begin
                filter_reg <= s_tdata;
                pos_reg    <= pngunf_pkg::POS_W'(1);
            end else if (rd_last) begin
                pos_reg <= '0;
            end else begin
                pos_reg <= pos_reg + pngunf_pkg::POS_W'(1);
            end
        end
    end

    // stage 1: row store read alongside the accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (data_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_accept) begin
            s1_raw_reg    <= s_tdata;
            s1_filter_reg <= filter_reg;
            s1_j_reg      <= rd_j;
            s1_fr_reg     <= s_tuser;
            s1_last_reg   <= rd_last;
            s1_hit_reg    <= pos_dec < fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_accept) begin
            rd_data_reg <= row_mem[rd_j];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            row_mem[s1_j_reg] <= recon;
        end
    end

    // reconstruction
    assign bpp_idx  = pngunf_pkg::PIX_IW'(bpp_eff - pngunf_pkg::BPP_W'(1));
    assign s1_start = s1_j_reg < pngunf_pkg::ROW_AW'(bpp_eff);
    assign stored   = s1_hit_reg ? rd_data_reg : '0;
    assign left_b   = s1_start ? '0 : left_hist_reg[bpp_idx];
    assign above_b  = s1_fr_reg ? '0 : stored;
    assign upleft_b = (s1_fr_reg || s1_start) ? '0 : ul_hist_reg[bpp_idx];
    assign avg_sum  = {1'b0, left_b} + {1'b0, above_b};

    always_comb begin
        case (s1_filter_reg)
            pngunf_pkg::FILT_SUB:   recon = s1_raw_reg + left_b;
            pngunf_pkg::FILT_UP:    recon = s1_raw_reg + above_b;
            pngunf_pkg::FILT_AVG:   recon = s1_raw_reg + avg_sum[8:1];
            pngunf_pkg::FILT_PAETH: recon = s1_raw_reg + pngunf_pkg::paeth(left_b, above_b,
                                                                             upleft_b);
            default:                recon = s1_raw_reg;
        endcase
    end

    assign s1_j_inc = pngunf_pkg::POS_W'(s1_j_reg) + pngunf_pkg::POS_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (s1_adv && (s1_j_inc > fill_reg)) begin
            fill_reg <= s1_j_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pngunf_pkg::MAX_PIXEL_BYTES; i++) begin
                left_hist_reg[i] <= '0;
                ul_hist_reg[i]   <= '0;
            end
        end else if (s1_adv) begin
            for (int i = pngunf_pkg::MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                left_hist_reg[i] <= left_hist_reg[i-1];
                ul_hist_reg[i]   <= ul_hist_reg[i-1];
            end
            left_hist_reg[0] <= recon;
            ul_hist_reg[0]   <= stored;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= recon;
            m_bad_reg  <= s1_filter_reg > pngunf_pkg::FILT_PAETH;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_bad_reg;
    assign m_tlast  = m_last_reg;

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_j_reg)))
        else $error("stage 1 lost a stalled byte");

    a_filter_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && pos_reg == '0) |=> !s1_valid_reg)
        else $error("filter type byte entered stage 1");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= pngunf_pkg::POS_W'(pngunf_pkg::MAX_ROW_BYTES))
        else $error("fill mark beyond row store");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= pngunf_pkg::POS_W'(pngunf_pkg::MAX_ROW_BYTES))
        else $error("row position beyond row length");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("output overwritten while stalled");

endmodule

`default_nettype wire

[tb/sv/png_scanline_unfilter_tb.sv]
module png_scanline_unfilter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 1600;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE       = 4;
    localparam int N_DIRECTED   = 32;
    localparam int CUT_BYTES    = 48;

    typedef struct packed {
        pngunf_pkg::byte_t pixel;
        logic              row_end;
        logic              bad;
    } pix_res_t;

    typedef enum int {ST_CFG, ST_DATA, ST_KNOWN} step_kind_t;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        step_kind_t           kind;
        pngunf_pkg::cfg_reg_t sel;
        int unsigned          val;
        logic                 fr;
        pix_res_t             want;
    } step_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata   = '0;
    logic                         s_tuser   = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [7:0]                   m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;
    logic                         cfg_we    = 1'b0;
    pngunf_pkg::cfg_reg_t         cfg_index = pngunf_pkg::REG_BPP;
    logic [pngunf_pkg::CFG_W-1:0] cfg_data  = '0;

    // predictor state
    logic [pngunf_pkg::BPP_W-1:0] bpp_reg = 4'd1;
    logic [pngunf_pkg::LEN_W-1:0] len_reg = 13'd1;
    pngunf_pkg::byte_t            row_above [pngunf_pkg::MAX_ROW_BYTES];
    pngunf_pkg::byte_t            left_hist [pngunf_pkg::MAX_PIXEL_BYTES];
    pngunf_pkg::byte_t            upleft_hist [pngunf_pkg::MAX_PIXEL_BYTES];
    int unsigned                  row_pos   = 0;
    pngunf_pkg::byte_t            row_filt  = pngunf_pkg::FILT_NONE;

    pix_res_t    pending_pix [$];
    idle_mode_t  idle_mode   = IDLE_NONE;
    int unsigned bytes_in    = 0;
    int unsigned pixels_out  = 0;
    int unsigned cfg_writes  = 0;
    int unsigned errors      = 0;
    int unsigned quiet_cycles = 0;

    png_scanline_unfilter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic bit roll(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int unsigned gap_pct();
        case (idle_mode)
            IDLE_SENDER: return 46;
            IDLE_BOTH:   return 33;
            default:     return 0;
        endcase
    endfunction

    function automatic int unsigned stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 46;
            IDLE_BOTH:     return 33;
            default:       return 0;
        endcase
    endfunction

    function automatic int unsigned clamp_len(input logic [pngunf_pkg::LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > pngunf_pkg::MAX_ROW_BYTES) return pngunf_pkg::MAX_ROW_BYTES;
        return len;
    endfunction

    function automatic int unsigned clamp_bpp(input logic [pngunf_pkg::BPP_W-1:0] bpp);
        if (bpp == 0) return 1;
        if (bpp > pngunf_pkg::MAX_PIXEL_BYTES) return pngunf_pkg::MAX_PIXEL_BYTES;
        return bpp;
    endfunction

    function automatic step_t cfg_step(input pngunf_pkg::cfg_reg_t sel,
                                       input int unsigned val);
        return '{ST_CFG, sel, val, 1'b0, '0};
    endfunction

    function automatic step_t data_step(input pngunf_pkg::byte_t raw, input logic fr);
        return '{ST_DATA, pngunf_pkg::REG_BPP, raw, fr, '0};
    endfunction

    function automatic step_t known_step(input pngunf_pkg::byte_t raw, input logic fr,
                                         input pix_res_t want);
        return '{ST_KNOWN, pngunf_pkg::REG_BPP, raw, fr, want};
    endfunction

    // ties go to left, then above, then upper-left
    function automatic pngunf_pkg::byte_t paeth_pick(input pngunf_pkg::byte_t a,
                                                     input pngunf_pkg::byte_t b,
                                                     input pngunf_pkg::byte_t c);
        int ia, ib, ic, da, db, dc;
        ia = a;
        ib = b;
        ic = c;
        da = ib - ic;
        db = ia - ic;
        dc = ia + ib - 2 * ic;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return a;
        return (db <= dc) ? b : c;
    endfunction

    task automatic unfilter_step(input pngunf_pkg::byte_t raw, input logic fr,
                                 output bit produced, output pix_res_t res);
        int unsigned       bpp, len, j;
        pngunf_pkg::byte_t stored, above, left, upleft, recon;
        logic [8:0]        avg_sum;
        produced = 1'b0;
        res      = '0;
        if (row_pos == 0) begin
            row_filt = raw;
            row_pos  = 1;
        end else begin
            bpp    = clamp_bpp(bpp_reg);
            len    = clamp_len(len_reg);
            j      = row_pos - 1;
            stored = row_above[j];
            above  = fr ? 8'h00 : stored;
            left   = (j < bpp) ? 8'h00 : left_hist[bpp-1];
            upleft = (fr || j < bpp) ? 8'h00 : upleft_hist[bpp-1];
            avg_sum = {1'b0, left} + {1'b0, above};
            case (row_filt)
                pngunf_pkg::FILT_SUB:   recon = raw + left;
                pngunf_pkg::FILT_UP:    recon = raw + above;
                pngunf_pkg::FILT_AVG:   recon = raw + avg_sum[8:1];
                pngunf_pkg::FILT_PAETH: recon = raw + paeth_pick(left, above, upleft);
                default:                recon = raw;
            endcase
            for (int i = pngunf_pkg::MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                left_hist[i]   = left_hist[i-1];
                upleft_hist[i] = upleft_hist[i-1];
            end
            left_hist[0]   = recon;
            upleft_hist[0] = stored;
            row_above[j]   = recon;
            produced = 1'b1;
            res.pixel   = recon;
            res.row_end = (j + 1) >= len;
            res.bad     = row_filt > pngunf_pkg::FILT_PAETH;
            row_pos = res.row_end ? 0 : row_pos + 1;
        end
    endtask

    task automatic push_byte(input pngunf_pkg::byte_t raw, input logic fr,
                             input bit typed, input pix_res_t known);
        bit       produced;
        pix_res_t res;
        while (roll(gap_pct())) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= fr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        unfilter_step(raw, fr, produced, res);
        if (produced) pending_pix.push_back(typed ? known : res);
        bytes_in++;
    endtask

    // filter bytes give no result, so allow the pipeline to settle too
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input pngunf_pkg::cfg_reg_t sel, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= pngunf_pkg::CFG_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (sel == pngunf_pkg::REG_BPP) bpp_reg = pngunf_pkg::BPP_W'(val);
        else len_reg = pngunf_pkg::LEN_W'(val);
        cfg_writes++;
    endtask

    task automatic flag_mismatch(input string what, input pix_res_t got, input pix_res_t want);
        errors++;
        $display("pixel %0d: %s: got %02h end %b bad %b, want %02h end %b bad %b",
                 pixels_out, what, got.pixel, got.row_end, got.bad,
                 want.pixel, want.row_end, want.bad);
    endtask

    always @(posedge aclk) begin
        pix_res_t got;
        pix_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tlast, m_tuser};
            if (pending_pix.size() == 0) begin
                flag_mismatch("unexpected transfer", got, '0);
            end else begin
                want = pending_pix.pop_front();
                if (got !== want) flag_mismatch("field mismatch", got, want);
            end
            pixels_out++;
        end
        m_tready <= !roll(stall_pct());
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("stalled: %0d cycles without a transfer", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        step_t                        directed [N_DIRECTED];
        int unsigned                  phase, n_rows, eff_len, n_data, random_items;
        logic [pngunf_pkg::LEN_W-1:0] len_cfg;
        logic                         row_fr;
        pngunf_pkg::byte_t            filt;

        directed = '{
            // after reset: bpp 1, length 1
            data_step(pngunf_pkg::FILT_NONE, 1'b0),
            known_step(8'hff, 1'b1, '{8'hff, 1'b1, 1'b0}),
            // unknown filter type passes bytes through
            data_step(8'hff, 1'b0),
            known_step(8'h00, 1'b0, '{8'h00, 1'b1, 1'b1}),
            // zero bpp reads as one
            cfg_step(pngunf_pkg::REG_BPP, 0),
            cfg_step(pngunf_pkg::REG_LEN, 3),
            data_step(pngunf_pkg::FILT_SUB, 1'b0),
            data_step(8'h01, 1'b1), data_step(8'h80, 1'b1), data_step(8'hff, 1'b0),
            data_step(pngunf_pkg::FILT_UP, 1'b0),
            data_step(8'h10, 1'b0), data_step(8'hf0, 1'b0), data_step(8'h7f, 1'b1),
            data_step(pngunf_pkg::FILT_AVG, 1'b0),
            data_step(8'hff, 1'b0), data_step(8'h01, 1'b0), data_step(8'h80, 1'b0),
            data_step(pngunf_pkg::FILT_PAETH, 1'b0),
            data_step(8'h33, 1'b0), data_step(8'hcc, 1'b0), data_step(8'h00, 1'b0),
            // saturating bpp and length
            cfg_step(pngunf_pkg::REG_BPP, 15),
            cfg_step(pngunf_pkg::REG_LEN, 13'h1fff),
            data_step(pngunf_pkg::FILT_PAETH, 1'b0),
            data_step(8'h55, 1'b1), data_step(8'haa, 1'b0),
            // shortened mid-row: next byte closes the row
            cfg_step(pngunf_pkg::REG_LEN, 1),
            data_step(8'h0f, 1'b0),
            // zero length reads as one
            cfg_step(pngunf_pkg::REG_LEN, 0),
            data_step(pngunf_pkg::FILT_AVG, 1'b0),
            data_step(8'hf0, 1'b1)
        };

        for (int k = 0; k < pngunf_pkg::MAX_ROW_BYTES; k++) row_above[k] = 8'h00;
        for (int k = 0; k < pngunf_pkg::MAX_PIXEL_BYTES; k++) begin
            left_hist[k]   = 8'h00;
            upleft_hist[k] = 8'h00;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[k]) begin
            case (directed[k].kind)
                ST_CFG: begin
                    quiesce();
                    write_reg(directed[k].sel, directed[k].val);
                end
                ST_DATA:  push_byte(pngunf_pkg::byte_t'(directed[k].val), directed[k].fr,
                                    1'b0, '0);
                default:  push_byte(pngunf_pkg::byte_t'(directed[k].val), directed[k].fr,
                                    1'b1, directed[k].want);
            endcase
        end

        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || phase < 8) begin
            idle_mode = idle_mode_t'(phase % 4);
            quiesce();
            write_reg(pngunf_pkg::REG_BPP,
                      (phase == 1) ? pngunf_pkg::MAX_PIXEL_BYTES : $urandom_range(0, 15));
            quiesce();
            if (phase == 6) begin
                len_cfg = 13'h1fff;
            end else begin
                case ($urandom_range(0, 9))
                    0:       len_cfg = pngunf_pkg::LEN_W'($urandom_range(0, 1));
                    1:       len_cfg = pngunf_pkg::LEN_W'($urandom_range(25, 400));
                    default: len_cfg = pngunf_pkg::LEN_W'($urandom_range(2, 24));
                endcase
            end
            write_reg(pngunf_pkg::REG_LEN, len_cfg);
            eff_len = clamp_len(len_cfg);
            n_rows  = (phase == 6) ? 1 : $urandom_range(3, 10);
            for (int r = 0; r < n_rows; r++) begin
                if (roll(10)) quiesce();
                row_fr = roll(25);
                filt = roll(88)
                     ? pngunf_pkg::byte_t'($urandom_range(pngunf_pkg::FILT_NONE,
                                                          pngunf_pkg::FILT_PAETH))
                     : pngunf_pkg::byte_t'($urandom_range(pngunf_pkg::FILT_PAETH + 1, 255));
                push_byte(filt, row_fr, 1'b0, '0);
                n_data = (phase == 6) ? CUT_BYTES : eff_len;
                for (int b = 0; b < n_data; b++) begin
                    if (roll(4)) row_fr = !row_fr;
                    push_byte(pngunf_pkg::byte_t'($urandom_range(0, 255)), row_fr, 1'b0, '0);
                end
                // saturated length: row closed by a shorter length
                if (phase == 6) begin
                    quiesce();
                    write_reg(pngunf_pkg::REG_LEN, 1);
                    push_byte(pngunf_pkg::byte_t'($urandom_range(0, 255)), row_fr, 1'b0, '0);
                    n_data++;
                end
                random_items += n_data + 1;
            end
            phase++;
        end

        quiesce();
        repeat (8) @(posedge aclk);

        $display("%0d bytes in, %0d pixel bytes checked, %0d register writes over %0d phases",
                 bytes_in, pixels_out, cfg_writes, phase);
        $display("all filter types incl. unknown, bpp 0..15, row lengths 0..8191, all stall modes");
        if (errors == 0 && pending_pix.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, pending_pix.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
